@@ sv/lswc_pkg.sv @@
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared constants for the line segment window clipper: register map of the
// configuration port.
// ----------------------------------------------------------------------------
package lswc_pkg;

  // configuration register index width
  localparam int unsigned CFG_IDX_BITS = 2;

  // configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIN_LEFT   = 2'd0,
    REG_WIN_BOTTOM = 2'd1,
    REG_WIN_RIGHT  = 2'd2,
    REG_WIN_TOP    = 2'd3
  } cfg_reg_t;

endpackage

@@ sv/line_segment_window_clipper_core.sv @@
// ----------------------------------------------------------------------------
// line_segment_window_clipper_core
// Liang-Barsky segment clipper with exact integer arithmetic, fully pipelined.
// ----------------------------------------------------------------------------
// One segment can be started on every clock cycle; busy is always low and the
// result is marked by a one-cycle out_valid strobe. The receiver cannot
// stall, so nothing is held back. The pipeline depth is set by the
// clipped-coordinate division: four restoring dividers run side by side,
// one quotient bit per pipeline stage (COORD_BITS+1 stages), behind five
// stages of edge setup, ratio compares and products.
// Window registers may only be written while no segment is in flight;
// cfg_ready is always high and writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module line_segment_window_clipper_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // segment input
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_BITS-1:0]         in_start_x,
  input  logic signed [COORD_BITS-1:0]         in_start_y,
  input  logic signed [COORD_BITS-1:0]         in_end_x,
  input  logic signed [COORD_BITS-1:0]         in_end_y,
  // result output
  output logic                                 out_valid,
  output logic                                 out_visible,
  output logic signed [COORD_BITS-1:0]         out_clip_start_x,
  output logic signed [COORD_BITS-1:0]         out_clip_start_y,
  output logic signed [COORD_BITS-1:0]         out_clip_end_x,
  output logic signed [COORD_BITS-1:0]         out_clip_end_y,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lswc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data
);

  import lswc_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned W  = COORD_BITS + 1;
  localparam int unsigned PW = 2 * W;

  localparam logic [C-1:0] RST_LEFT   = C'(0);
  localparam logic [C-1:0] RST_BOTTOM = C'(0);
  localparam logic [C-1:0] RST_RIGHT  = C'(639);
  localparam logic [C-1:0] RST_TOP    = C'(479);

  // per-axis entry/exit fractions, all non-negative once not rejected
  typedef struct packed {
    logic         rej;
    logic [W-1:0] mag;
    logic [W-1:0] en;
    logic [W-1:0] ed;
    logic [W-1:0] xn;
    logic [W-1:0] xd;
  } axis_t;

  // entry and exit fractions of an axis from its delta and both of its edge distances
  function automatic axis_t axis_fn(input logic signed [W-1:0] d,
                                    input logic signed [W-1:0] lo_q,
                                    input logic signed [W-1:0] hi_q);
    axis_t               r;
    logic [W-1:0]        a;
    logic signed [W-1:0] n;
    logic signed [W-1:0] x;
    begin
      a     = d[W-1] ? W'(-d) : W'(d);
      n     = d[W-1] ? -hi_q : -lo_q;
      x     = d[W-1] ? lo_q : hi_q;
      r.rej = 1'b0;
      r.mag = a;
      r.en  = '0;
      r.ed  = W'(1);
      r.xn  = W'(1);
      r.xd  = W'(1);
      if (d == '0) begin
        r.rej = lo_q[W-1] | hi_q[W-1];
      end else begin
        // entering ratio, max with zero; above one means rejected
        if (!n[W-1] && (n != '0)) begin
          if ($unsigned(n) > a) begin
            r.rej = 1'b1;
          end else begin
            r.en = $unsigned(n);
            r.ed = a;
          end
        end
        // leaving ratio, min with one; below zero means rejected
        if (x[W-1]) begin
          r.rej = 1'b1;
        end else if ($unsigned(x) < a) begin
          r.xn = $unsigned(x);
          r.xd = a;
        end
      end
      return r;
    end
  endfunction

  // one restoring division step, returns {remainder, shifted dividend/quotient}
  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rem,
                                              input logic [W-1:0] acc,
                                              input logic [W-1:0] den);
    logic [W:0] r2;
    logic [W:0] diff;
    logic       ge;
    begin
      r2   = {rem, acc[W-1]};
      diff = r2 - {1'b0, den};
      ge   = (r2 >= {1'b0, den});
      return {(ge ? diff[W-1:0] : r2[W-1:0]), acc[W-2:0], ge};
    end
  endfunction

  // window registers
  logic signed [C-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= RST_LEFT;
      win_bottom_r <= RST_BOTTOM;
      win_right_r  <= RST_RIGHT;
      win_top_r    <= RST_TOP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIN_LEFT:   win_left_r   <= cfg_data;
        REG_WIN_BOTTOM: win_bottom_r <= cfg_data;
        REG_WIN_RIGHT:  win_right_r  <= cfg_data;
        REG_WIN_TOP:    win_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: deltas and edge distances
  logic                s1_v_r;
  logic signed [C-1:0] s1_sx_r, s1_sy_r;
  logic signed [W-1:0] s1_dx_r, s1_dy_r;
  logic signed [W-1:0] s1_ql_r, s1_qr_r, s1_qb_r, s1_qt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_sx_r <= in_start_x;
    s1_sy_r <= in_start_y;
    s1_dx_r <= W'(in_end_x) - W'(in_start_x);
    s1_dy_r <= W'(in_end_y) - W'(in_start_y);
    s1_ql_r <= W'(in_start_x) - W'(win_left_r);
    s1_qr_r <= W'(win_right_r) - W'(in_start_x);
    s1_qb_r <= W'(in_start_y) - W'(win_bottom_r);
    s1_qt_r <= W'(win_top_r) - W'(in_start_y);
  end

  // stage 2: per-axis entry and exit fractions
  logic                s2_v_r;
  logic signed [C-1:0] s2_sx_r, s2_sy_r;
  logic                s2_xneg_r, s2_yneg_r;
  axis_t               s2_ax_r, s2_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    s2_sx_r   <= s1_sx_r;
    s2_sy_r   <= s1_sy_r;
    s2_xneg_r <= s1_dx_r[W-1];
    s2_yneg_r <= s1_dy_r[W-1];
    s2_ax_r   <= axis_fn(s1_dx_r, s1_ql_r, s1_qr_r);
    s2_ay_r   <= axis_fn(s1_dy_r, s1_qb_r, s1_qt_r);
  end

  // stage 3: cross products to rank the two axes
  logic                s3_v_r, s3_rej_r;
  logic signed [C-1:0] s3_sx_r, s3_sy_r;
  logic                s3_xneg_r, s3_yneg_r;
  axis_t               s3_ax_r, s3_ay_r;
  logic [PW-1:0]       s3_inx_r, s3_iny_r, s3_outx_r, s3_outy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    s3_rej_r  <= s2_ax_r.rej | s2_ay_r.rej;
    s3_sx_r   <= s2_sx_r;
    s3_sy_r   <= s2_sy_r;
    s3_xneg_r <= s2_xneg_r;
    s3_yneg_r <= s2_yneg_r;
    s3_ax_r   <= s2_ax_r;
    s3_ay_r   <= s2_ay_r;
    s3_inx_r  <= s2_ax_r.en * s2_ay_r.ed;
    s3_iny_r  <= s2_ay_r.en * s2_ax_r.ed;
    s3_outx_r <= s2_ax_r.xn * s2_ay_r.xd;
    s3_outy_r <= s2_ay_r.xn * s2_ax_r.xd;
  end

  // stage 4: t_in is the larger entry, t_out the smaller exit
  logic                s4_v_r, s4_rej_r;
  logic signed [C-1:0] s4_sx_r, s4_sy_r;
  logic                s4_xneg_r, s4_yneg_r;
  logic [W-1:0]        s4_mx_r, s4_my_r;
  logic [W-1:0]        s4_in_n_r, s4_in_d_r, s4_out_n_r, s4_out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    s4_rej_r  <= s3_rej_r;
    s4_sx_r   <= s3_sx_r;
    s4_sy_r   <= s3_sy_r;
    s4_xneg_r <= s3_xneg_r;
    s4_yneg_r <= s3_yneg_r;
    s4_mx_r   <= s3_ax_r.mag;
    s4_my_r   <= s3_ay_r.mag;
    if (s3_inx_r >= s3_iny_r) begin
      s4_in_n_r <= s3_ax_r.en;
      s4_in_d_r <= s3_ax_r.ed;
    end else begin
      s4_in_n_r <= s3_ay_r.en;
      s4_in_d_r <= s3_ay_r.ed;
    end
    if (s3_outx_r <= s3_outy_r) begin
      s4_out_n_r <= s3_ax_r.xn;
      s4_out_d_r <= s3_ax_r.xd;
    end else begin
      s4_out_n_r <= s3_ay_r.xn;
      s4_out_d_r <= s3_ay_r.xd;
    end
  end

  // stage 5: visibility products and the four dividends
  logic                s5_v_r, s5_rej_r;
  logic signed [C-1:0] s5_sx_r, s5_sy_r;
  logic                s5_xneg_r, s5_yneg_r;
  logic [W-1:0]        s5_den_r [2];
  logic [PW-1:0]       s5_cin_r, s5_cout_r;
  logic [PW-1:0]       s5_div_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else        s5_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    s5_rej_r    <= s4_rej_r;
    s5_sx_r     <= s4_sx_r;
    s5_sy_r     <= s4_sy_r;
    s5_xneg_r   <= s4_xneg_r;
    s5_yneg_r   <= s4_yneg_r;
    s5_den_r[0] <= s4_in_d_r;
    s5_den_r[1] <= s4_out_d_r;
    s5_cin_r    <= s4_in_n_r * s4_out_d_r;
    s5_cout_r   <= s4_out_n_r * s4_in_d_r;
    s5_div_r[0] <= s4_in_n_r * s4_mx_r;
    s5_div_r[1] <= s4_in_n_r * s4_my_r;
    s5_div_r[2] <= s4_out_n_r * s4_mx_r;
    s5_div_r[3] <= s4_out_n_r * s4_my_r;
  end

  // divider pipeline: lanes are t_in*|dx|, t_in*|dy|, t_out*|dx|, t_out*|dy|
  logic                dv_v_r    [W];
  logic                dv_vis_r  [W];
  logic signed [C-1:0] dv_sx_r   [W];
  logic signed [C-1:0] dv_sy_r   [W];
  logic                dv_xneg_r [W];
  logic                dv_yneg_r [W];
  logic [W-1:0]        dv_den_r  [W][2];
  logic [W-1:0]        dv_rem_r  [W][4];
  logic [W-1:0]        dv_acc_r  [W][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < W; k++) dv_v_r[k] <= 1'b0;
    end else begin
      dv_v_r[0] <= s5_v_r;
      for (int k = 1; k < W; k++) dv_v_r[k] <= dv_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    dv_vis_r[0]    <= !s5_rej_r && (s5_cin_r <= s5_cout_r);
    dv_sx_r[0]     <= s5_sx_r;
    dv_sy_r[0]     <= s5_sy_r;
    dv_xneg_r[0]   <= s5_xneg_r;
    dv_yneg_r[0]   <= s5_yneg_r;
    dv_den_r[0][0] <= s5_den_r[0];
    dv_den_r[0][1] <= s5_den_r[1];
    for (int l = 0; l < 4; l++) begin
      {dv_rem_r[0][l], dv_acc_r[0][l]} <=
        div_step(s5_div_r[l][PW-1:W], s5_div_r[l][W-1:0], s5_den_r[l/2]);
    end
    for (int k = 1; k < W; k++) begin
      dv_vis_r[k]    <= dv_vis_r[k-1];
      dv_sx_r[k]     <= dv_sx_r[k-1];
      dv_sy_r[k]     <= dv_sy_r[k-1];
      dv_xneg_r[k]   <= dv_xneg_r[k-1];
      dv_yneg_r[k]   <= dv_yneg_r[k-1];
      dv_den_r[k][0] <= dv_den_r[k-1][0];
      dv_den_r[k][1] <= dv_den_r[k-1][1];
      for (int l = 0; l < 4; l++) begin
        {dv_rem_r[k][l], dv_acc_r[k][l]} <=
          div_step(dv_rem_r[k-1][l], dv_acc_r[k-1][l], dv_den_r[k-1][l/2]);
      end
    end
  end

  // output stage: start point plus signed offset, zero when rejected
  logic [W-1:0] sx_w, sy_w;
  logic [W-1:0] cx_in_nxt, cy_in_nxt, cx_out_nxt, cy_out_nxt;

  assign sx_w = W'(dv_sx_r[W-1]);
  assign sy_w = W'(dv_sy_r[W-1]);

  always_comb begin
    cx_in_nxt  = dv_xneg_r[W-1] ? sx_w - dv_acc_r[W-1][0] : sx_w + dv_acc_r[W-1][0];
    cy_in_nxt  = dv_yneg_r[W-1] ? sy_w - dv_acc_r[W-1][1] : sy_w + dv_acc_r[W-1][1];
    cx_out_nxt = dv_xneg_r[W-1] ? sx_w - dv_acc_r[W-1][2] : sx_w + dv_acc_r[W-1][2];
    cy_out_nxt = dv_yneg_r[W-1] ? sy_w - dv_acc_r[W-1][3] : sy_w + dv_acc_r[W-1][3];
  end

  logic                out_valid_r, out_visible_r;
  logic signed [C-1:0] out_sx_r, out_sy_r, out_ex_r, out_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_v_r[W-1];
  end

  always_ff @(posedge clk) begin
    out_visible_r <= dv_vis_r[W-1];
    if (dv_vis_r[W-1]) begin
      out_sx_r <= cx_in_nxt[C-1:0];
      out_sy_r <= cy_in_nxt[C-1:0];
      out_ex_r <= cx_out_nxt[C-1:0];
      out_ey_r <= cy_out_nxt[C-1:0];
    end else begin
      out_sx_r <= '0;
      out_sy_r <= '0;
      out_ex_r <= '0;
      out_ey_r <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = out_visible_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;

  // assertions
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |->
      (out_clip_start_x == '0) && (out_clip_start_y == '0) &&
      (out_clip_end_x == '0) && (out_clip_end_y == '0))
    else $error("rejected segment with nonzero coordinates");

  a_entry_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s2_ax_r.rej && !s2_ay_r.rej |->
      (s2_ax_r.en <= s2_ax_r.ed) && (s2_ay_r.en <= s2_ay_r.ed) &&
      (s2_ax_r.xn <= s2_ax_r.xd) && (s2_ay_r.xn <= s2_ay_r.xd))
    else $error("axis fraction outside [0,1]");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_in_d_r != '0) && (s4_out_d_r != '0))
    else $error("zero divisor entering divider");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    s5_v_r && !s5_rej_r && (s5_cin_r <= s5_cout_r) |->
      (s5_div_r[0][PW-1:W] < s5_den_r[0]) && (s5_div_r[2][PW-1:W] < s5_den_r[1]))
    else $error("quotient would overflow divider");

  a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[W-1] |=> out_valid)
    else $error("result strobe lost at output stage");

endmodule
